// ----- rtl/core/tlv_element_walker_core_macros.svh -----
// ----------------------------------------------------------------------------
// TLV element walker assertion macros
// Shared concurrent assertion forms for the element walker core.
// ----------------------------------------------------------------------------
`ifndef TLV_ELEMENT_WALKER_CORE_MACROS_SVH
`define TLV_ELEMENT_WALKER_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define TLVEW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define TLVEW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/tlvew_pkg.sv -----
// ----------------------------------------------------------------------------
// TLV element walker package
// Types, widths and helpers shared by the element walker core and its queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvew_pkg;

   localparam int OFFSET_BITS  = 20;
   localparam int OUT_OFFSET_W = 20;
   localparam int TAG_W        = 16;
   localparam int LEN_W        = 16;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = ((TAG_W + LEN_W + OUT_OFFSET_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - (TAG_W + LEN_W + OUT_OFFSET_W);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_TAG_HI = 3'd0,
      PH_TAG_LO = 3'd1,
      PH_LEN_HI = 3'd2,
      PH_LEN_LO = 3'd3,
      PH_VALUE  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ELEM    = 2'd0,
      KIND_END     = 2'd1,
      KIND_TRUNC   = 2'd2,
      KIND_OVERRUN = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [TAG_W-1:0]        tag;
      logic [LEN_W-1:0]        length;
      logic [OUT_OFFSET_W-1:0] offset;
      logic                    last;
   } rsp_type;

   // Results produced by one request: num is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [OFFSET_BITS-1:0] offset_inc(input logic [OFFSET_BITS-1:0] v);
      return (v == OFFSET_MAX) ? v : v + OFFSET_BITS'(1);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tlvew_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// TLV element walker result queue
// Small register queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvew_rsp_queue
   import tlvew_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          space_ok,
   output logic          out_valid,
   input  wire logic     out_ready,
   output rsp_type       out_item
);

   rsp_type             entries_ff [QDEPTH];
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = entries_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // room for a full pair of results
   assign space_ok  = (count_ff <= QCNT_W'(QDEPTH - 2));

   always_comb begin
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      wr_ptr_in = QPTR_W'(wr_ptr_ff + QPTR_W'(push.num));
      count_in  = QCNT_W'(count_ff + QCNT_W'(push.num) - QCNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         entries_ff[QPTR_W'(wr_ptr_ff + 1'b1)] <= push.second;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/tlv_element_walker_core.sv -----
// ----------------------------------------------------------------------------
// TLV element walker core
// Splits a byte stream into tag/length/value elements and reports each one.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle on the request side (tlast on the final
// byte) and walks elements made of a 16-bit big-endian tag, a 16-bit
// big-endian length and that many value bytes. A result is produced when an
// element's value completes (or right after the header for a zero length),
// and the final byte also yields an end status: clean end, header truncated
// or value overrun. The parser state updates in the cycle a request is taken,
// so a byte can be accepted every cycle; results go into a four-entry queue
// that drains one result per cycle while the receiver is ready, in order from
// its registers. Only a byte that completes an element on the final byte
// gives two results, and at least three bytes lie between two such bytes, so
// with an always-ready receiver the queue never holds more than two results
// and the request side takes one byte every cycle. The request side stalls
// only when receiver backpressure leaves fewer than two free queue entries.
// Offsets saturate at 2^20-1 and restart at zero after each final byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tlv_element_walker_core_macros.svh"

module tlv_element_walker_core
   import tlvew_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] data_byte
   input  wire logic                  req_tlast,  // last_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [15:0] elem_tag, [31:16] elem_length,
                                                  // [51:32] value_offset, [55:52] zero
   output logic [1:0]                 rsp_tuser,  // [1:0] result_kind
   output logic                       rsp_tlast   // last_of_run
);

   phase_type              phase_ff, phase_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [LEN_W-1:0]       left_ff, left_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [OFFSET_BITS-1:0] vstart_ff, vstart_in;

   logic      req_accept;
   logic      in_header;
   logic      done_elem;
   rsp_type   elem_rsp;
   rsp_type   end_rsp;
   kind_type  end_kind;
   push_type  push;
   rsp_type   out_item;

   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      phase_in  = phase_ff;
      tag_in    = tag_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      vstart_in = vstart_ff;
      off_in    = off_ff;
      in_header = 1'b0;
      done_elem = 1'b0;
      if (req_accept) begin
         unique case (phase_ff)
            PH_TAG_LO: begin
               tag_in    = {tag_ff[TAG_W-1:8], req_tdata};
               phase_in  = PH_LEN_HI;
               in_header = 1'b1;
            end
            PH_LEN_HI: begin
               len_in    = {req_tdata, 8'h00};
               phase_in  = PH_LEN_LO;
               in_header = 1'b1;
            end
            PH_LEN_LO: begin
               len_in    = {len_ff[LEN_W-1:8], req_tdata};
               vstart_in = offset_inc(off_ff);
               left_in   = len_in;
               if (len_in == '0) begin
                  done_elem = 1'b1;
                  phase_in  = PH_TAG_HI;
               end else begin
                  phase_in  = PH_VALUE;
               end
            end
            PH_VALUE: begin
               left_in = LEN_W'(left_ff - 1'b1);
               if (left_in == '0) begin
                  done_elem = 1'b1;
                  phase_in  = PH_TAG_HI;
               end
            end
            default: begin
               tag_in    = {req_tdata, 8'h00};
               phase_in  = PH_TAG_LO;
               in_header = 1'b1;
            end
         endcase
         off_in = offset_inc(off_ff);
      end
   end

   // Status reported on the final byte
   always_comb begin
      priority if (in_header) begin
         end_kind = KIND_TRUNC;
      end else if (phase_in == PH_VALUE) begin
         end_kind = KIND_OVERRUN;
      end else begin
         end_kind = KIND_END;
      end
   end

   always_comb begin
      elem_rsp.kind   = KIND_ELEM;
      elem_rsp.tag    = tag_in;
      elem_rsp.length = len_in;
      elem_rsp.offset = OUT_OFFSET_W'(vstart_in);
      elem_rsp.last   = !req_tlast;

      end_rsp.kind    = end_kind;
      end_rsp.tag     = '0;
      end_rsp.length  = '0;
      end_rsp.offset  = '0;
      end_rsp.last    = 1'b1;

      push.first  = done_elem ? elem_rsp : end_rsp;
      push.second = end_rsp;
      if (!req_accept) begin
         push.num = 2'd0;
      end else begin
         push.num = 2'(done_elem) + 2'(req_tlast);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG_HI;
         tag_ff    <= '0;
         len_ff    <= '0;
         left_ff   <= '0;
         off_ff    <= '0;
         vstart_ff <= '0;
      end else if (req_accept && req_tlast) begin
         // restart for the next message
         phase_ff  <= PH_TAG_HI;
         tag_ff    <= '0;
         len_ff    <= '0;
         left_ff   <= '0;
         off_ff    <= '0;
         vstart_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         len_ff    <= len_in;
         left_ff   <= left_in;
         off_ff    <= off_in;
         vstart_ff <= vstart_in;
      end
   end

   tlvew_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, out_item.offset, out_item.length, out_item.tag};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

   `TLVEW_ASSERT_NEXT(a_restart_after_last, clock, reset,
      req_accept && req_tlast, phase_ff == PH_TAG_HI && off_ff == '0,
      "walker did not restart after the final byte")
   `TLVEW_ASSERT_SAME(a_status_ends_run, clock, reset,
      rsp_tvalid && rsp_tuser != KIND_ELEM, rsp_tlast,
      "end status result not marked last of run")
   `TLVEW_ASSERT_SAME(a_value_count_live, clock, reset,
      phase_ff == PH_VALUE, left_ff != '0,
      "value phase with no bytes left")

endmodule

`default_nettype wire
